@@ sv/b64e_pkg.sv @@
// b64e_pkg: shared types, constants and the character map for the base64 stream encoder.
// No dependencies; every module of the encoder imports it.
package b64e_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CharW  = 7;
  localparam int unsigned SextW  = 6;
  localparam int unsigned NcharW = 3;  // holds 2, 3 or 4

  localparam logic [CharW-1:0]  PadChar   = 7'd61;  // '='
  localparam logic [NcharW-1:0] NcharFull = 3'd4;
  localparam logic [NcharW-1:0] NcharOne  = 3'd2;   // one byte held: 2 chars + "=="
  localparam logic [NcharW-1:0] NcharTwo  = 3'd3;   // two bytes held: 3 chars + "="

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             run_last;
  } out_item_t;

  // One complete or zero-filled 24-bit group plus its count of alphabet chars.
  typedef struct packed {
    logic [ByteW-1:0]  b0;
    logic [ByteW-1:0]  b1;
    logic [ByteW-1:0]  b2;
    logic [NcharW-1:0] n_chars;
  } group_t;

  typedef struct packed {
    logic   vld;
    group_t grp;
  } grp_req_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [CharW-1:0] b64_char(input logic [SextW-1:0] idx);
    logic [CharW-1:0] c;
    logic [CharW-1:0] x;
    x = {1'b0, idx};
    case (idx) inside
      [6'd0:6'd25]:  c = 7'd65 + x;            // 'A'
      [6'd26:6'd51]: c = 7'd97 + x - 7'd26;    // 'a'
      [6'd52:6'd61]: c = 7'd48 + x - 7'd52;    // '0'
      6'd62:         c = 7'd43;                // '+'
      default:       c = 7'd47;                // '/'
    endcase
    return c;
  endfunction

endpackage

@@ sv/b64e_front.sv @@
// b64e_front: accepts input bytes, gathers them into groups of three, hands groups on.
// Depends on b64e_pkg.
module b64e_front import b64e_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     q_full_i,
  output grp_req_t push_o
);

  logic [1:0]       cnt_q, cnt_d;
  logic [ByteW-1:0] b0_q, b0_d, b1_q, b1_d;
  logic             acc;

  assign in_stall_o = q_full_i;
  assign acc        = in_valid_i & ~q_full_i;

  always_comb begin
    cnt_d  = cnt_q;
    b0_d   = b0_q;
    b1_d   = b1_q;
    push_o = '0;
    if (acc) begin
      if (cnt_q == 2'd2) begin
        push_o.vld = 1'b1;
        push_o.grp = '{b0: b0_q, b1: b1_q, b2: in_item_i.data_byte, n_chars: NcharFull};
        cnt_d      = 2'd0;
      end else if (in_item_i.end_of_message) begin
        push_o.vld = 1'b1;
        if (cnt_q == 2'd0) begin
          push_o.grp = '{b0: in_item_i.data_byte, b1: '0, b2: '0, n_chars: NcharOne};
        end else begin
          push_o.grp = '{b0: b0_q, b1: in_item_i.data_byte, b2: '0, n_chars: NcharTwo};
        end
        cnt_d = 2'd0;
      end else begin
        if (cnt_q == 2'd0) begin
          b0_d = in_item_i.data_byte;
        end else begin
          b1_d = in_item_i.data_byte;
        end
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b0_q <= b0_d;
    b1_q <= b1_d;
  end

endmodule

@@ sv/b64e_queue.sv @@
// b64e_queue: two-entry group queue between the front and back ends.
// Depends on b64e_pkg.
module b64e_queue import b64e_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  grp_req_t push_i,
  output logic     full_o,
  output logic     valid_o,
  output group_t   head_o,
  input  logic     pop_i
);

  group_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i.vld) wr_q <= ~wr_q;
      if (do_pop)     rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i.vld} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.vld) mem_q[wr_q] <= push_i.grp;
  end

endmodule

@@ sv/b64e_back.sv @@
// b64e_back: splits each queued group into four 6-bit values and emits one char per cycle when not stalled.
// Depends on b64e_pkg.
module b64e_back import b64e_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  group_t    head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic [1:0]       k_q;
  logic             ov_q;
  out_item_t        out_q;
  logic             load;
  logic [SextW-1:0] sext;
  logic [CharW-1:0] ch;

  assign load = q_valid_i & (~ov_q | ~out_stall_i);
  assign pop_o = load & (k_q == 2'd3);

  always_comb begin
    case (k_q)
      2'd0:    sext = head_i.b0[7:2];
      2'd1:    sext = {head_i.b0[1:0], head_i.b1[7:4]};
      2'd2:    sext = {head_i.b1[3:0], head_i.b2[7:6]};
      default: sext = head_i.b2[5:0];
    endcase
    ch = ({1'b0, k_q} < head_i.n_chars) ? b64_char(sext) : PadChar;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= 2'd0;
      ov_q <= 1'b0;
    end else begin
      if (load) k_q <= k_q + 2'd1;
      ov_q <= load | (ov_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.char_code <= ch;
      out_q.run_last  <= (k_q == 2'd3);
    end
  end

  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;

endmodule

@@ sv/base64_stream_encoder.sv @@
// base64_stream_encoder: top level of the streaming base64 encoder (standard alphabet).
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i): one raw byte per item plus
//   an end_of_message flag on the final byte of a message. An item is taken at a
//   clock edge with valid high and stall low.
//   Output channel (out_valid_o / out_stall_i / out_item_o): one ASCII char per item.
//   Every third byte, and every final byte, yields four chars; run_last marks the
//   fourth. A partial final group is zero-filled and padded with '='.
// Timing:
//   Front end takes one byte per cycle as long as the two-entry group queue has room.
//   Back end emits one char per cycle while out_stall_i is low, four per group; the
//   chars of a group are loaded one by one from the queue head into the output register.
//   Sustained rate is set by the back end: 4 chars per 3 bytes on full groups and
//   4 chars per one-byte message.
// Reset: clears the held byte count, the queue, the char index and the output valid
//   flag; no init sweep, the block accepts items as soon as reset is released.
// Stall: out_stall_i holds the output register; the queue fills and then
//   in_stall_o rises until the back end frees an entry.
module base64_stream_encoder import b64e_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  grp_req_t push;
  logic     q_full, q_valid, pop;
  group_t   head;

  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  b64e_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head),
    .pop_i   (pop)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
